/* hw/rtl/assert_macros.svh */
// assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define AST_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// next-cycle implication under reset
`define AST_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

/* hw/rtl/sph_pkg.sv */
// ----------------------------------------------------------------------------
// sph_pkg
// Shared types and constants of the segregated page heap allocator.
// ----------------------------------------------------------------------------
package sph_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int PAGE_SHIFT      = 12;
	localparam int PAGE_BITS       = 20;
	localparam int PAGES_W         = 21;
	localparam int ENTRY_W         = PAGE_BITS + PAGES_W;

	localparam logic [PAGES_W-1:0] SMALL_PAGES = 21'd4;
	localparam logic [PAGES_W-1:0] MID_PAGES   = 21'd16;
	localparam logic [31:0]        REUSE_THR_RST = 32'h8000_0000;
	localparam logic [6:0]         REL_MAX = 7'd127;

	localparam logic [1:0] OP_ALLOC    = 2'd0;
	localparam logic [1:0] OP_FREE     = 2'd1;
	localparam logic [1:0] OP_WITHDRAW = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ZERO      = 3'd1;
	localparam logic [2:0] ST_UNKNOWN   = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_EXHAUSTED = 3'd4;

	localparam logic CFG_HEAP_BASE = 1'b0;
	localparam logic CFG_REUSE_THR = 1'b1;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] request_size;
		logic [31:0] block_address;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] granted_address;
		logic [6:0]  blocks_released;
		logic [31:0] heap_top;
	} rsp_t;

endpackage

/* hw/rtl/segregated_page_heap_allocator_core.sv */
// ----------------------------------------------------------------------------
// segregated_page_heap_allocator_core
// Page heap allocator with bump pointer and best-fit free block reuse.
// ----------------------------------------------------------------------------
// One request at a time. Allocate, free and each withdraw round walk the block
// table in memory one entry per cycle; a split adds the S_SPLIT state, withdraw
// takes one table walk per released block plus one, and zero-size, null free,
// unaligned free and spare opcodes skip the table walk. A finished response sits
// in an output register, so the next request is taken while it waits.
module segregated_page_heap_allocator_core #(
	parameter int TABLE_DEPTH = sph_pkg::TABLE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sph_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sph_pkg::rsp_t rsp_data,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_wdata
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int PW = sph_pkg::PAGES_W;
	localparam int BW = sph_pkg::PAGE_BITS;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_SPLIT, S_FINISH} state_t;

	state_t state_q;
	logic [31:0] base_q, thr_q, heap_end_q;
	logic [TABLE_DEPTH-1:0] valid_q, free_q;
	logic [1:0] op_q;
	logic [PW-1:0] req_pages_q;
	logic [BW-1:0] addr_page_q;
	logic reuse_q;
	logic [IW-1:0] idx_q;
	logic chk_s1;
	logic [IW-1:0] chk_idx_s1;
	logic ex_hit_q, bf_hit_q, emp_hit_q;
	logic [IW-1:0] ex_idx_q, bf_idx_q, emp_idx_q;
	logic [BW-1:0] ex_page_q, bf_page_q;
	logic [PW-1:0] bf_pages_q;
	logic [2:0] st_q;
	logic [31:0] grant_q;
	logic [6:0] rel_q;
	sph_pkg::rsp_t out_q;
	logic out_valid_q;

	logic ram_we, ram_re;
	logic [IW-1:0] ram_waddr;
	logic [sph_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [BW-1:0] e_page;
	logic [PW-1:0] e_pages;
	logic e_v, e_f;
	logic is_small_mid, ex_take, bf_take, emp_take, mt_take, top_take;
	logic [PW-1:0] req_round;
	logic [32:0] new_end;
	logic split_ok;

	sph_table_ram #(.DEPTH(TABLE_DEPTH), .IW(IW)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;
	assign ram_re    = (state_q == S_SCAN);

	assign e_page  = ram_rdata[sph_pkg::ENTRY_W-1:PW];
	assign e_pages = ram_rdata[PW-1:0];
	assign e_v     = valid_q[chk_idx_s1];
	assign e_f     = free_q[chk_idx_s1];

	assign req_round = PW'(({1'b0, req_data.request_size} + 33'h0_0000_0FFF)
		>> sph_pkg::PAGE_SHIFT);
	assign is_small_mid = (req_pages_q == sph_pkg::SMALL_PAGES)
		|| (req_pages_q == sph_pkg::MID_PAGES);

	assign ex_take = chk_s1 && e_v && e_f && is_small_mid && (e_pages == req_pages_q)
		&& (!ex_hit_q || e_page < ex_page_q);
	assign bf_take = chk_s1 && e_v && e_f && (e_pages != sph_pkg::SMALL_PAGES)
		&& (e_pages != sph_pkg::MID_PAGES) && (e_pages >= req_pages_q)
		&& (!bf_hit_q || e_pages < bf_pages_q || (e_pages == bf_pages_q && e_page < bf_page_q));
	assign emp_take = chk_s1 && !e_v && !emp_hit_q;
	assign mt_take  = chk_s1 && e_v && !ex_hit_q && (e_page == addr_page_q);
	assign top_take = chk_s1 && e_v && (!bf_hit_q || e_page > bf_page_q);

	assign new_end  = {1'b0, heap_end_q} + {req_pages_q, 12'h000};
	assign split_ok = ({1'b0, bf_pages_q} > {req_pages_q, 1'b0})
		&& (bf_pages_q > sph_pkg::MID_PAGES) && emp_hit_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = emp_idx_q;
		ram_wdata = {heap_end_q[31:sph_pkg::PAGE_SHIFT], req_pages_q};
		if (state_q == S_DECIDE && op_q == sph_pkg::OP_ALLOC) begin
			if (reuse_q && ex_hit_q) begin
				ram_we = 1'b0;
			end else if (reuse_q && bf_hit_q) begin
				ram_we    = split_ok;
				ram_waddr = bf_idx_q;
				ram_wdata = {bf_page_q, req_pages_q};
			end else begin
				ram_we = emp_hit_q && !new_end[32];
			end
		end else if (state_q == S_SPLIT) begin
			ram_we    = 1'b1;
			ram_wdata = {BW'(bf_page_q + req_pages_q[BW-1:0]), PW'(bf_pages_q - req_pages_q)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			thr_q       <= sph_pkg::REUSE_THR_RST;
			heap_end_q  <= '0;
			valid_q     <= '0;
			free_q      <= '0;
			chk_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			ex_hit_q    <= 1'b0;
			bf_hit_q    <= 1'b0;
			emp_hit_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == sph_pkg::CFG_HEAP_BASE) begin
					base_q <= {cfg_wdata[31:sph_pkg::PAGE_SHIFT], 12'h000};
					if (valid_q == '0) begin
						heap_end_q <= {cfg_wdata[31:sph_pkg::PAGE_SHIFT], 12'h000};
					end
				end else begin
					thr_q <= cfg_wdata;
				end
			end
			if (out_valid_q && !rsp_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			chk_s1     <= (state_q == S_SCAN);
			chk_idx_s1 <= idx_q;
			// scan result tracking
			if (op_q == sph_pkg::OP_ALLOC) begin
				if (ex_take) begin
					ex_hit_q  <= 1'b1;
					ex_idx_q  <= chk_idx_s1;
					ex_page_q <= e_page;
				end
				if (bf_take) begin
					bf_hit_q   <= 1'b1;
					bf_idx_q   <= chk_idx_s1;
					bf_page_q  <= e_page;
					bf_pages_q <= e_pages;
				end
			end else if (op_q == sph_pkg::OP_FREE) begin
				if (mt_take) begin
					ex_hit_q <= 1'b1;
					ex_idx_q <= chk_idx_s1;
				end
			end else begin
				if (top_take) begin
					bf_hit_q   <= 1'b1;
					bf_idx_q   <= chk_idx_s1;
					bf_page_q  <= e_page;
					bf_pages_q <= e_pages;
				end
			end
			if (emp_take) begin
				emp_hit_q <= 1'b1;
				emp_idx_q <= chk_idx_s1;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q        <= req_data.opcode;
						req_pages_q <= req_round;
						addr_page_q <= req_data.block_address[31:sph_pkg::PAGE_SHIFT];
						reuse_q     <= (heap_end_q - base_q) >= thr_q;
						idx_q       <= '0;
						ex_hit_q    <= 1'b0;
						bf_hit_q    <= 1'b0;
						emp_hit_q   <= 1'b0;
						st_q        <= sph_pkg::ST_OK;
						grant_q     <= '0;
						rel_q       <= '0;
						state_q     <= S_SCAN;
						case (req_data.opcode)
							sph_pkg::OP_ALLOC: begin
								if (req_data.request_size == '0) begin
									st_q    <= sph_pkg::ST_ZERO;
									state_q <= S_FINISH;
								end
							end
							sph_pkg::OP_FREE: begin
								if (req_data.block_address == '0) begin
									state_q <= S_FINISH;
								end else if (req_data.block_address[11:0] != '0) begin
									st_q    <= sph_pkg::ST_UNKNOWN;
									state_q <= S_FINISH;
								end
							end
							sph_pkg::OP_WITHDRAW: begin
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IW'(TABLE_DEPTH - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= S_FINISH;
					case (op_q)
						sph_pkg::OP_ALLOC: begin
							if (reuse_q && ex_hit_q) begin
								free_q[ex_idx_q] <= 1'b0;
								grant_q <= {ex_page_q, 12'h000};
							end else if (reuse_q && bf_hit_q) begin
								free_q[bf_idx_q] <= 1'b0;
								grant_q <= {bf_page_q, 12'h000};
								if (split_ok) begin
									state_q <= S_SPLIT;
								end
							end else if (!emp_hit_q) begin
								st_q <= sph_pkg::ST_FULL;
							end else if (new_end[32]) begin
								st_q <= sph_pkg::ST_EXHAUSTED;
							end else begin
								valid_q[emp_idx_q] <= 1'b1;
								free_q[emp_idx_q]  <= 1'b0;
								grant_q            <= heap_end_q;
								heap_end_q         <= new_end[31:0];
							end
						end
						sph_pkg::OP_FREE: begin
							if (ex_hit_q) begin
								free_q[ex_idx_q] <= 1'b1;
							end else begin
								st_q <= sph_pkg::ST_UNKNOWN;
							end
						end
						default: begin
							if (bf_hit_q && free_q[bf_idx_q]) begin
								heap_end_q <= heap_end_q - 32'({bf_pages_q, 12'h000});
								valid_q[bf_idx_q] <= 1'b0;
								free_q[bf_idx_q]  <= 1'b0;
								if (rel_q != sph_pkg::REL_MAX) begin
									rel_q <= rel_q + 1'b1;
								end
								bf_hit_q <= 1'b0;
								idx_q    <= '0;
								state_q  <= S_SCAN;
							end
						end
					endcase
				end
				S_SPLIT: begin
					valid_q[emp_idx_q] <= 1'b1;
					free_q[emp_idx_q]  <= 1'b1;
					state_q            <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || !rsp_stall) begin
						out_valid_q           <= 1'b1;
						out_q.status          <= st_q;
						out_q.granted_address <= grant_q;
						out_q.blocks_released <= rel_q;
						out_q.heap_top        <= heap_end_q;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/sph_table_ram.sv */
// ----------------------------------------------------------------------------
// sph_table_ram
// Block table storage: start page and page count, registered read.
// ----------------------------------------------------------------------------
module sph_table_ram #(
	parameter int DEPTH = sph_pkg::TABLE_DEPTH_DEF,
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [IW-1:0]              waddr,
	input  logic [sph_pkg::ENTRY_W-1:0] wdata,
	input  logic                       re,
	input  logic [IW-1:0]              raddr,
	output logic [sph_pkg::ENTRY_W-1:0] rdata
);

	logic [sph_pkg::ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/sph_checker.sv */
// ----------------------------------------------------------------------------
// sph_checker
// Port-level checks of the allocator response channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sph_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input sph_pkg::rsp_t rsp_data
);

	`AST_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid)
	`AST_NXT(a_rsp_stable, clk, arst_n, rsp_valid && rsp_stall, $stable(rsp_data))
	`AST_IMP(a_status_range, clk, arst_n, rsp_valid, rsp_data.status < 3'd5)
	`AST_IMP(a_fail_no_grant, clk, arst_n, rsp_valid && rsp_data.status != sph_pkg::ST_OK, rsp_data.granted_address == '0)
	`AST_IMP(a_release_clean, clk, arst_n, rsp_valid && rsp_data.blocks_released != '0, rsp_data.status == sph_pkg::ST_OK && rsp_data.granted_address == '0)

endmodule

bind segregated_page_heap_allocator_core sph_checker u_sph_checker (.*);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the segregated page heap allocator core. A driver
// and a monitor run as clocked processes around the block. Every accepted
// request is run through a bench-side model of the block table and the bump
// pointer. The response it predicts is queued and compared field by field
// with what comes out. The run covers several register settings: a directed
// opening, then random mixes of all four opcodes, mostly with random idling.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = sph_pkg::TABLE_DEPTH_DEF;
	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int NONE = -1;

	logic clk, arst_n;
	logic req_valid, req_stall, rsp_valid, rsp_stall;
	sph_pkg::req_t req_data;
	sph_pkg::rsp_t rsp_data;
	logic cfg_we, cfg_index;
	logic [31:0] cfg_wdata;

	segregated_page_heap_allocator_core dut (.*);

	// model of the block
	logic [19:0] blk_page [DEPTH];
	logic [20:0] blk_pages [DEPTH];
	bit blk_used [DEPTH];
	bit blk_free [DEPTH];
	logic [31:0] heap_end, heap_base, reuse_thr;

	sph_pkg::req_t pending_reqs[$];
	sph_pkg::rsp_t expected_rsps[$];
	int errors = 0;
	int rsp_count = 0;
	bit idle_on = 1'b1;
	bit req_taken, rsp_taken;
	int send_gap, rsp_hold;

	function automatic int empty_slot();
		for (int i = 0; i < DEPTH; i++)
			if (!blk_used[i])
				return i;
		return NONE;
	endfunction

	function automatic int reuse_block(logic [20:0] want);
		int idx;
		int slot;
		logic [20:0] total;
		idx = NONE;
		if (want == sph_pkg::SMALL_PAGES || want == sph_pkg::MID_PAGES) begin
			for (int i = 0; i < DEPTH; i++)
				if (blk_used[i] && blk_free[i] && blk_pages[i] == want &&
						(idx == NONE || blk_page[i] < blk_page[idx]))
					idx = i;
			if (idx != NONE) begin
				blk_free[idx] = 1'b0;
				return idx;
			end
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (!blk_used[i] || !blk_free[i])
				continue;
			if (blk_pages[i] == sph_pkg::SMALL_PAGES || blk_pages[i] == sph_pkg::MID_PAGES
					|| blk_pages[i] < want)
				continue;
			if (idx == NONE || blk_pages[i] < blk_pages[idx] ||
					(blk_pages[i] == blk_pages[idx] && blk_page[i] < blk_page[idx]))
				idx = i;
		end
		if (idx == NONE)
			return NONE;
		blk_free[idx] = 1'b0;
		total = blk_pages[idx];
		if ({1'b0, total} > {want, 1'b0} && total > sph_pkg::MID_PAGES) begin
			slot = empty_slot();
			if (slot != NONE) begin
				blk_pages[idx] = want;
				blk_page[slot] = blk_page[idx] + want[19:0];
				blk_pages[slot] = total - want;
				blk_used[slot] = 1'b1;
				blk_free[slot] = 1'b1;
			end
		end
		return idx;
	endfunction

	function automatic sph_pkg::rsp_t heap_response(sph_pkg::req_t r);
		sph_pkg::rsp_t o;
		logic [32:0] pages;
		logic [63:0] new_end;
		int idx;
		int top;
		o = '0;
		o.status = sph_pkg::ST_OK;
		case (r.opcode)
			sph_pkg::OP_ALLOC: begin
				pages = ({1'b0, r.request_size} + 33'hFFF) >> sph_pkg::PAGE_SHIFT;
				if (r.request_size == 0) begin
					o.status = sph_pkg::ST_ZERO;
				end else begin
					idx = NONE;
					if (heap_end - heap_base >= reuse_thr)
						idx = reuse_block(pages[20:0]);
					if (idx != NONE) begin
						o.granted_address = {blk_page[idx], 12'h000};
					end else begin
						idx = empty_slot();
						new_end = {32'b0, heap_end} + ({31'b0, pages} << sph_pkg::PAGE_SHIFT);
						if (idx == NONE) begin
							o.status = sph_pkg::ST_FULL;
						end else if (new_end > 64'hFFFF_FFFF) begin
							o.status = sph_pkg::ST_EXHAUSTED;
						end else begin
							blk_page[idx] = heap_end[31:12];
							blk_pages[idx] = pages[20:0];
							blk_used[idx] = 1'b1;
							blk_free[idx] = 1'b0;
							o.granted_address = heap_end;
							heap_end = new_end[31:0];
						end
					end
				end
			end
			sph_pkg::OP_FREE: begin
				if (r.block_address != 0) begin
					o.status = sph_pkg::ST_UNKNOWN;
					if (r.block_address[11:0] == 12'h000) begin
						for (int i = 0; i < DEPTH; i++)
							if (blk_used[i] && blk_page[i] == r.block_address[31:12]) begin
								blk_free[i] = 1'b1;
								o.status = sph_pkg::ST_OK;
								break;
							end
					end
				end
			end
			sph_pkg::OP_WITHDRAW: begin
				forever begin
					top = NONE;
					for (int i = 0; i < DEPTH; i++)
						if (blk_used[i] && (top == NONE || blk_page[i] > blk_page[top]))
							top = i;
					if (top == NONE || !blk_free[top])
						break;
					heap_end = heap_end - {blk_pages[top][19:0], 12'h000};
					blk_used[top] = 1'b0;
					blk_free[top] = 1'b0;
					if (o.blocks_released != sph_pkg::REL_MAX)
						o.blocks_released = o.blocks_released + 7'd1;
				end
			end
			default: ;
		endcase
		o.heap_top = heap_end;
		return o;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("tb: failure");
		$finish;
	end

	// request acceptance, prediction, response check, register update
	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				blk_used[i] = 1'b0;
				blk_free[i] = 1'b0;
			end
			heap_base = 32'h0;
			heap_end = 32'h0;
			reuse_thr = sph_pkg::REUSE_THR_RST;
		end else begin
			req_taken <= req_valid && !req_stall;
			rsp_taken <= rsp_valid && !rsp_stall;
			if (req_valid && !req_stall)
				expected_rsps.push_back(heap_response(req_data));
			if (rsp_valid && !rsp_stall) begin
				rsp_count++;
				if (expected_rsps.size() == 0) begin
					errors++;
					$error("unexpected response %p", rsp_data);
				end else begin
					sph_pkg::rsp_t e;
					e = expected_rsps.pop_front();
					if (e.status !== rsp_data.status) begin
						errors++;
						$error("status exp %0d got %0d", e.status, rsp_data.status);
					end
					if (e.granted_address !== rsp_data.granted_address) begin
						errors++;
						$error("granted_address exp %h got %h", e.granted_address,
							rsp_data.granted_address);
					end
					if (e.blocks_released !== rsp_data.blocks_released) begin
						errors++;
						$error("blocks_released exp %0d got %0d", e.blocks_released,
							rsp_data.blocks_released);
					end
					if (e.heap_top !== rsp_data.heap_top) begin
						errors++;
						$error("heap_top exp %h got %h", e.heap_top, rsp_data.heap_top);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == sph_pkg::CFG_HEAP_BASE) begin
					bit any;
					any = 1'b0;
					heap_base = {cfg_wdata[31:12], 12'h000};
					for (int i = 0; i < DEPTH; i++)
						any |= blk_used[i];
					if (!any)
						heap_end = heap_base;
				end else begin
					reuse_thr = cfg_wdata;
				end
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
			send_gap <= 0;
		end else if (!req_valid || req_taken) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				req_data <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				send_gap <= idle_on ? $urandom_range(0, 11) : 0;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response stall
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			rsp_hold <= 0;
		end else if (rsp_taken) begin
			if (rsp_count == 400)
				rsp_hold <= 900;
			else
				rsp_hold <= idle_on ? $urandom_range(0, 11) : 0;
			rsp_stall <= 1'b1;
		end else if (rsp_hold > 0) begin
			rsp_hold <= rsp_hold - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic push_req(logic [1:0] op, logic [31:0] size, logic [31:0] addr);
		sph_pkg::req_t r;
		r.opcode = op;
		r.request_size = size;
		r.block_address = addr;
		while (pending_reqs.size() > 2)
			@(posedge clk);
		pending_reqs.push_back(r);
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic clear_heap();
		bit any;
		for (int n = 0; n < 4; n++) begin
			wait_idle();
			any = 1'b0;
			for (int i = 0; i < DEPTH; i++)
				if (blk_used[i]) begin
					any = 1'b1;
					push_req(sph_pkg::OP_FREE, 32'd0, {blk_page[i], 12'h000});
				end
			if (!any)
				break;
			push_req(sph_pkg::OP_WITHDRAW, 32'd0, 32'd0);
		end
		wait_idle();
	endtask

	function automatic logic [31:0] pick_size();
		int k;
		k = $urandom_range(0, 99);
		if (k < 30)
			return 32'h4000 - $urandom_range(0, 4095);
		if (k < 45)
			return 32'h10000;
		if (k < 80)
			return $urandom_range(1, 20 * 4096);
		if (k < 90)
			return $urandom_range(1, 32'h10_0000);
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_block();
		int live[$];
		for (int i = 0; i < DEPTH; i++)
			if (blk_used[i])
				live.push_back(i);
		if (live.size() == 0)
			return $urandom & 32'hFFFF_F000;
		return {blk_page[live[$urandom_range(0, live.size() - 1)]], 12'h000};
	endfunction

	task automatic random_mix(int count);
		int k;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(0, 99);
			if (k < 50)
				push_req(sph_pkg::OP_ALLOC, pick_size(), $urandom);
			else if (k < 75)
				push_req(sph_pkg::OP_FREE, $urandom, pick_block());
			else if (k < 83)
				push_req(sph_pkg::OP_WITHDRAW, $urandom, $urandom);
			else if (k < 87)
				push_req(sph_pkg::OP_FREE, $urandom, $urandom);
			else if (k < 91)
				push_req(sph_pkg::OP_FREE, $urandom, pick_block() | $urandom_range(1, 4095));
			else if (k < 95)
				push_req(OP_NOP, $urandom, $urandom);
			else
				push_req(sph_pkg::OP_ALLOC, 32'd0, $urandom);
		end
	endtask

	initial begin
		logic [31:0] bases [6];
		logic [31:0] thrs [6];
		bases = '{32'h0, 32'h1_0000, 32'hFFFF_FFFF, 32'h7FFF_F123, 32'h0, 32'h1234_5000};
		thrs = '{sph_pkg::REUSE_THR_RST, 32'h0, 32'h0, 32'h4_0000, 32'hFFFF_FFFF,
			32'h10_0000};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sph_pkg::CFG_HEAP_BASE;
		cfg_wdata = 32'h0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(sph_pkg::CFG_HEAP_BASE, 32'h1000);
		write_reg(sph_pkg::CFG_REUSE_THR, 32'h0);
		push_req(sph_pkg::OP_ALLOC, 32'd0, 32'd0);
		push_req(sph_pkg::OP_ALLOC, 32'd1, 32'd0);
		push_req(sph_pkg::OP_ALLOC, 32'h4000, 32'd0);
		push_req(sph_pkg::OP_ALLOC, 32'h1_0000, 32'd0);
		push_req(sph_pkg::OP_ALLOC, 32'h5000, 32'd0);
		push_req(sph_pkg::OP_ALLOC, 32'd204800, 32'd0);
		push_req(sph_pkg::OP_FREE, 32'd0, 32'h2001);
		push_req(sph_pkg::OP_FREE, 32'd0, 32'h0);
		push_req(sph_pkg::OP_FREE, 32'd0, 32'hFFFF_F000);
		push_req(sph_pkg::OP_FREE, 32'd0, 32'h2000);
		push_req(sph_pkg::OP_FREE, 32'd0, 32'h2000);
		push_req(sph_pkg::OP_ALLOC, 32'h4000, 32'd0);
		push_req(sph_pkg::OP_FREE, 32'd0, 32'h1B000);
		push_req(sph_pkg::OP_ALLOC, 32'h3000, 32'd0);
		push_req(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(sph_pkg::OP_WITHDRAW, 32'd0, 32'd0);
		push_req(sph_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
		push_req(sph_pkg::OP_FREE, 32'd0, 32'h6000);
		push_req(sph_pkg::OP_ALLOC, 32'h1_0000, 32'd0);
		push_req(sph_pkg::OP_WITHDRAW, 32'd0, 32'd0);
		clear_heap();
		push_req(sph_pkg::OP_WITHDRAW, 32'd0, 32'd0);

		for (int p = 0; p < 6; p++) begin
			clear_heap();
			idle_on = (p != 4);
			write_reg(sph_pkg::CFG_HEAP_BASE, bases[p]);
			write_reg(sph_pkg::CFG_REUSE_THR, thrs[p]);
			random_mix(300);
		end
		wait_idle();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/sph_pkg.sv
hw/rtl/sph_table_ram.sv
hw/rtl/segregated_page_heap_allocator_core.sv
hw/rtl/sph_checker.sv
test/tb.sv
